### rtl/msfp_pkg.sv
// shared types and constants for the maximum spanning forest block
`timescale 1ns / 1ps
package msfp_pkg;

  localparam int unsigned END_W    = 5;
  localparam int unsigned IN_W_W   = 16;
  localparam int unsigned EIDX_W   = 6;
  localparam int unsigned NCNT_W   = 6;
  localparam logic [NCNT_W-1:0] NCNT_RESET = 6'd32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [END_W-1:0]  edge_source;
    logic [END_W-1:0]  edge_target;
    logic [IN_W_W-1:0] edge_weight;
  } msfp_in_t;

  typedef struct packed {
    logic [END_W-1:0]  node_number;
    logic              has_parent;
    logic [END_W-1:0]  parent_node;
    logic [EIDX_W-1:0] edge_index;
    logic              last;
  } msfp_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_JOIN_RD,
    S_JOIN_EW,
    S_JOIN_BW,
    S_OUT_RN,
    S_OUT_RE,
    S_OUT_PUT,
    S_FINISH
  } msfp_state_t;

  typedef struct packed {
    logic accept;
    logic run_clear;
    logic scan_init;
    logic scan_run;
    logic join_begin;
    logic edge_rd;
    logic edge_lat;
    logic best_chk;
    logic out_init;
    logic out_rn;
    logic out_lat;
    logic out_put;
    logic edges_clear;
  } msfp_cmd_t;

  typedef struct packed {
    logic run_go;
    logic n_zero;
    logic scan_end;
    logic pick_found;
    logic start_found;
    logic edge_end;
    logic slot_free;
    logic out_last;
  } msfp_stat_t;

endpackage

### rtl/msfp_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module msfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/msfp_ctrl.sv
// sequencer for loading, tree growth scans and result emission
`timescale 1ns / 1ps
module msfp_ctrl import msfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  msfp_stat_t stat,
  output msfp_cmd_t  cmd
);

  msfp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.run_go) begin
          state_nxt = stat.n_zero ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = (stat.pick_found || stat.start_found) ? S_JOIN_RD : S_OUT_RN;
        end
      end
      S_JOIN_RD: state_nxt = stat.edge_end ? S_SCAN : S_JOIN_EW;
      S_JOIN_EW: state_nxt = S_JOIN_BW;
      S_JOIN_BW: state_nxt = S_JOIN_RD;
      S_OUT_RN:  state_nxt = S_OUT_RE;
      S_OUT_RE:  state_nxt = S_OUT_PUT;
      S_OUT_PUT: begin
        if (stat.slot_free) begin
          state_nxt = stat.out_last ? S_FINISH : S_OUT_RN;
        end
      end
      S_FINISH:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept    = 1'b1;
        cmd.run_clear = stat.run_go;
        cmd.scan_init = stat.run_go && !stat.n_zero;
      end
      S_SCAN: begin
        cmd.scan_run   = 1'b1;
        cmd.join_begin = stat.scan_end && (stat.pick_found || stat.start_found);
        cmd.out_init   = stat.scan_end && !(stat.pick_found || stat.start_found);
      end
      S_JOIN_RD: begin
        cmd.edge_rd   = !stat.edge_end;
        cmd.scan_init = stat.edge_end;
      end
      S_JOIN_EW: cmd.edge_lat = 1'b1;
      S_JOIN_BW: cmd.best_chk = 1'b1;
      S_OUT_RN:  cmd.out_rn   = 1'b1;
      S_OUT_RE:  cmd.out_lat  = 1'b1;
      S_OUT_PUT: cmd.out_put  = stat.slot_free;
      S_FINISH:  cmd.edges_clear = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

### rtl/msfp_dpath.sv
// edge store, node offers, scan and result registers
`timescale 1ns / 1ps
module msfp_dpath import msfp_pkg::*; #(
  parameter int unsigned MAX_NODES   = 32,
  parameter int unsigned MAX_EDGES   = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  msfp_cmd_t         cmd,
  output msfp_stat_t        stat,
  input  logic              in_valid,
  output logic              in_ready,
  input  msfp_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output msfp_out_t         out_data,
  input  logic              cfg_we,
  input  logic [NCNT_W-1:0] cfg_wdata
);

  localparam int unsigned NIW  = $clog2(MAX_NODES);
  localparam int unsigned NCW  = $clog2(MAX_NODES + 1);
  localparam int unsigned CW   = (NCW > NCNT_W) ? NCW : NCNT_W;
  localparam int unsigned EIW  = $clog2(MAX_EDGES);
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EDW  = 2 * END_W + WEIGHT_BITS;
  localparam int unsigned NDW  = WEIGHT_BITS + EIW;
  localparam logic [CW-1:0] MAXN_C = CW'(MAX_NODES);
  localparam logic [ECW-1:0] MAXE_C = ECW'(MAX_EDGES);

  logic [NCNT_W-1:0] node_count_r;
  logic [CW-1:0]     n_c;
  logic [ECW-1:0]    cnt_r;
  logic [ECW-1:0]    e_r;

  logic [MAX_NODES-1:0] done_r, wait_r, hpar_r;

  logic [CW-1:0]          sc_r;
  logic                   d_vld_r;
  logic [NIW-1:0]         d_idx_r;
  logic                   pick_v_r, first_v_r;
  logic [NIW-1:0]         pick_r, first_r;
  logic [WEIGHT_BITS-1:0] pick_w_r;

  // ju_r is the joining node, jv_r the far end of the edge in flight
  logic [NIW-1:0]         ju_r;
  logic [NIW-1:0]         jv_r;
  logic [WEIGHT_BITS-1:0] jw_r;
  logic [EIW-1:0]         je_r;
  logic                   jel_r;

  logic [NIW-1:0] o_r;
  logic           ohp_r;
  logic [EIW-1:0] oe_r;

  logic           out_valid_r;
  msfp_out_t      out_data_r;

  // edge ram: {end a, end b, weight}
  logic           e_we, e_re;
  logic [EIW-1:0] e_raddr;
  logic [EDW-1:0] e_wdata, e_rdata;
  logic [END_W-1:0]       ea, eb;
  logic [WEIGHT_BITS-1:0] ew;

  // node ram: {best weight, chosen edge}
  logic           n_we, n_re;
  logic [NIW-1:0] n_raddr;
  logic [NDW-1:0] n_wdata, n_rdata;
  logic [WEIGHT_BITS-1:0] nb_w;
  logic [EIW-1:0]         nb_e;

  logic           load_go;
  logic [CW-1:0]  ea_c, eb_c, u_c, v_c, o_c;
  logic [NIW-1:0] u_idx;
  logic           touches, elig, upd;

  assign n_c = (CW'(node_count_r) > MAXN_C) ? MAXN_C : CW'(node_count_r);

  assign in_ready = cmd.accept;
  assign load_go  = in_valid && cmd.accept && (in_data.opcode == OP_LOAD) && (cnt_r < MAXE_C);

  assign {ea, eb, ew}  = e_rdata;
  assign {nb_w, nb_e}  = n_rdata;

  assign u_idx   = pick_v_r ? pick_r : first_r;
  assign ea_c    = CW'(ea);
  assign eb_c    = CW'(eb);
  assign u_c     = CW'(ju_r);
  assign touches = (ea_c == u_c) || (eb_c == u_c);
  assign v_c     = (ea_c == u_c) ? eb_c : ea_c;
  assign elig    = touches && (v_c < n_c) && !done_r[v_c[NIW-1:0]];
  assign upd     = cmd.best_chk && jel_r && (!wait_r[jv_r] || (jw_r > nb_w));
  assign o_c     = CW'(o_r);

  assign e_we    = load_go;
  assign e_wdata = {in_data.edge_source, in_data.edge_target,
                    WEIGHT_BITS'(in_data.edge_weight)};
  assign e_re    = cmd.edge_rd || cmd.out_lat;
  assign e_raddr = cmd.out_lat ? nb_e : e_r[EIW-1:0];

  assign n_we    = upd;
  assign n_wdata = {jw_r, je_r};
  assign n_re    = (cmd.scan_run && (sc_r < n_c)) || cmd.edge_lat || cmd.out_rn;
  always_comb begin
    if (cmd.edge_lat) begin
      n_raddr = v_c[NIW-1:0];
    end else if (cmd.out_rn) begin
      n_raddr = o_r;
    end else begin
      n_raddr = sc_r[NIW-1:0];
    end
  end

  msfp_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (cnt_r[EIW-1:0]),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  msfp_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (jv_r),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCNT_RESET;
      cnt_r        <= '0;
      done_r       <= '0;
      wait_r       <= '0;
      hpar_r       <= '0;
      d_vld_r      <= 1'b0;
      pick_v_r     <= 1'b0;
      first_v_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (load_go) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.edges_clear) begin
        cnt_r <= '0;
      end
      if (cmd.run_clear) begin
        done_r <= '0;
        wait_r <= '0;
        hpar_r <= '0;
      end
      if (cmd.scan_init) begin
        d_vld_r   <= 1'b0;
        pick_v_r  <= 1'b0;
        first_v_r <= 1'b0;
      end else if (cmd.scan_run) begin
        d_vld_r <= (sc_r < n_c);
        if (d_vld_r) begin
          // strict compare keeps the lowest index on equal offers
          if (wait_r[d_idx_r] && (!pick_v_r || (nb_w > pick_w_r))) begin
            pick_v_r <= 1'b1;
          end
          if (!done_r[d_idx_r]) begin
            first_v_r <= 1'b1;
          end
        end
      end
      if (cmd.join_begin) begin
        done_r[u_idx] <= 1'b1;
        wait_r[u_idx] <= 1'b0;
      end
      if (upd) begin
        wait_r[jv_r] <= 1'b1;
        hpar_r[jv_r] <= 1'b1;
      end
      if (cmd.out_put) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      sc_r <= '0;
    end else if (cmd.scan_run) begin
      d_idx_r <= sc_r[NIW-1:0];
      if (sc_r < n_c) begin
        sc_r <= sc_r + 1'b1;
      end
      if (d_vld_r) begin
        if (wait_r[d_idx_r] && (!pick_v_r || (nb_w > pick_w_r))) begin
          pick_r   <= d_idx_r;
          pick_w_r <= nb_w;
        end
        if (!done_r[d_idx_r] && !first_v_r) begin
          first_r <= d_idx_r;
        end
      end
    end
    if (cmd.join_begin) begin
      ju_r <= u_idx;
      e_r  <= '0;
    end
    if (cmd.edge_lat) begin
      jel_r <= elig;
      jw_r  <= ew;
      je_r  <= e_r[EIW-1:0];
      jv_r  <= v_c[NIW-1:0];
      e_r   <= e_r + 1'b1;
    end
    if (cmd.out_init) begin
      o_r <= '0;
    end
    if (cmd.out_lat) begin
      ohp_r <= hpar_r[o_r];
      oe_r  <= nb_e;
    end
    if (cmd.out_put) begin
      out_data_r.node_number <= END_W'(o_r);
      out_data_r.has_parent  <= ohp_r;
      out_data_r.parent_node <= ohp_r ? ((eb_c == o_c) ? ea : eb) : '0;
      out_data_r.edge_index  <= ohp_r ? EIDX_W'(oe_r) : '0;
      out_data_r.last        <= (o_c == n_c - 1'b1);
      o_r <= o_r + 1'b1;
    end
  end

  assign stat.run_go      = in_valid && cmd.accept && (in_data.opcode == OP_RUN);
  assign stat.n_zero      = (n_c == '0);
  assign stat.scan_end    = (sc_r == n_c) && !d_vld_r;
  assign stat.pick_found  = pick_v_r;
  assign stat.start_found = first_v_r;
  assign stat.edge_end    = (e_r == cnt_r);
  assign stat.slot_free   = !out_valid_r || out_ready;
  assign stat.out_last    = (o_c == n_c - 1'b1);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/max_spanning_forest_prim_core.sv
// top level of the maximum spanning forest block
//
// channel  dir  handshake        payload
// in_      in   valid / ready    msfp_in_t  (load edge or run)
// out_     out  valid / ready    msfp_out_t (one item per node on a run)
// cfg_     in   write enable     node_count
//
// a load item is accepted from idle; loads stream back to back from idle
// a run alternates scans of the node offers with, for each node joined, a pass
// over every stored edge, then emits the result items one per node
// synchronous active-low reset; node count resets to 32, edge store empty
// a stalled output holds the sequencer in its emit step
`timescale 1ns / 1ps
module max_spanning_forest_prim_core import msfp_pkg::*; #(
  parameter int unsigned MAX_NODES   = 32,
  parameter int unsigned MAX_EDGES   = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msfp_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output msfp_out_t         out_data,
  input  logic              cfg_we,
  input  logic [NCNT_W-1:0] cfg_wdata
);

  msfp_cmd_t  cmd;
  msfp_stat_t stat;

  msfp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  msfp_dpath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

### verif/msfp_checker.sv
// checker for the maximum spanning forest block: edge store model, forest prediction, compare
`timescale 1ns / 1ps
module msfp_checker import msfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  msfp_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  msfp_out_t         out_data,
  input  logic              cfg_we,
  input  logic [NCNT_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending_count
);

  localparam int NODES = 32;
  localparam int EDGES = 64;

  logic [END_W-1:0]  store_a [EDGES];
  logic [END_W-1:0]  store_b [EDGES];
  logic [IN_W_W-1:0] store_w [EDGES];
  int                stored_edges;
  logic [NCNT_W-1:0] node_count;
  msfp_out_t         forest_queue[$];

  task automatic grow_forest();
    int   n, pick, start, e, v;
    logic [16:0] offer [NODES];
    bit   joined [NODES];
    bit   waiting [NODES];
    int   parent_edge [NODES];
    msfp_out_t r;
    n = (node_count > NODES) ? NODES : node_count;
    for (int i = 0; i < NODES; i++) begin
      offer[i] = 17'h10000;
      joined[i] = 0;
      waiting[i] = 0;
      parent_edge[i] = -1;
    end
    forever begin
      start = n;
      for (int i = n - 1; i >= 0; i--) if (!joined[i]) start = i;
      if (start >= n) break;
      pick = start;
      while (pick < n) begin
        joined[pick] = 1;
        waiting[pick] = 0;
        for (e = 0; e < stored_edges; e++) begin
          if (store_a[e] != pick && store_b[e] != pick) continue;
          v = (store_a[e] == pick) ? store_b[e] : store_a[e];
          if (v >= n || joined[v]) continue;
          if (offer[v][16] || {1'b0, store_w[e]} > offer[v]) begin
            offer[v] = {1'b0, store_w[e]};
            parent_edge[v] = e;
            waiting[v] = 1;
          end
        end
        pick = n;
        for (int i = 0; i < n; i++)
          if (waiting[i] && (pick >= n || offer[i] > offer[pick])) pick = i;
      end
    end
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.node_number = i[END_W-1:0];
      if (parent_edge[i] >= 0) begin
        e = parent_edge[i];
        r.has_parent = 1'b1;
        r.parent_node = (store_b[e] == i) ? store_a[e] : store_b[e];
        r.edge_index = e[EIDX_W-1:0];
      end
      r.last = (i + 1 == n);
      forest_queue.push_back(r);
    end
    stored_edges = 0;
  endtask

  always @(posedge clk) begin
    msfp_out_t want;
    if (!rst_n) begin
      node_count <= NCNT_RESET;
      stored_edges = 0;
      fail_count = 0;
      forest_queue.delete();
    end else begin
      if (cfg_we) node_count <= cfg_wdata;
      if (out_valid && out_ready) begin
        if (forest_queue.size() == 0) begin
          $display("%0t: unexpected item, actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = forest_queue.pop_front();
          if (out_data !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_LOAD) begin
          if (stored_edges < EDGES) begin
            store_a[stored_edges] = in_data.edge_source;
            store_b[stored_edges] = in_data.edge_target;
            store_w[stored_edges] = in_data.edge_weight;
            stored_edges++;
          end
        end else begin
          grow_forest();
        end
      end
    end
    pending_count = forest_queue.size();
  end

endmodule

### verif/tb_top.sv
// testbench top for the maximum spanning forest block: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import msfp_pkg::*;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_ready;
  msfp_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 0;
  msfp_out_t         out_data;
  logic              cfg_we = 0;
  logic [NCNT_W-1:0] cfg_wdata = '0;
  int                fail_count;
  int                pending_count;
  int                cycle_count = 0;
  bit                stall_quiet = 0;

  localparam int CYCLE_LIMIT = 2000000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  max_spanning_forest_prim_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  msfp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  function automatic int gap_len();
    if (stall_quiet) return 0;
    if ($urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst_n) out_ready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays up after an accept until the next gap or idle point
  task automatic send_item(input logic op, input int src, input int dst, input int wt);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.opcode <= op;
    in_data.edge_source <= src[END_W-1:0];
    in_data.edge_target <= dst[END_W-1:0];
    in_data.edge_weight <= wt[IN_W_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_edge(input int src, input int dst, input int wt);
    send_item(OP_LOAD, src, dst, wt);
  endtask

  task automatic run_forest();
    send_item(OP_RUN, $urandom, $urandom, $urandom);
  endtask

  // idle point: all results back, then room for the block to settle
  task automatic set_node_count(input int n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n[NCNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random graph of mostly valid edges, some foreign ends and self loops
  task automatic random_graph(input int n, input int edge_total);
    int s, d, lim;
    lim = (n < 1) ? 0 : n - 1;
    for (int k = 0; k < edge_total; k++) begin
      s = $urandom_range(0, lim);
      d = $urandom_range(0, lim);
      if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 31);
      if ($urandom_range(0, 3) == 0)
        load_edge(s, d, $urandom_range(0, 7));
      else
        load_edge(s, d, $urandom);
    end
    run_forest();
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset node count of 32, extremes of fields, ties, self loop
    load_edge(0, 31, 16'hffff);
    load_edge(31, 1, 0);
    load_edge(1, 2, 5);
    load_edge(2, 1, 5);
    load_edge(3, 3, 100);
    load_edge(4, 5, 16'h5555);
    load_edge(5, 4, 16'haaaa);
    run_forest();
    set_node_count(4);
    load_edge(0, 1, 7);
    load_edge(1, 2, 7);
    load_edge(0, 2, 7);
    load_edge(2, 9, 999);
    run_forest();
    set_node_count(0);
    load_edge(0, 1, 3);
    run_forest();
    set_node_count(1);
    run_forest();
    set_node_count(63);
    // full store: loads beyond the limit are dropped
    for (int k = 0; k < 70; k++)
      load_edge($urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    run_forest();

    for (int ph = 0; ph < 3; ph++) begin
      n = (ph == 0) ? 2 : (ph == 1) ? 32 : $urandom_range(1, 12);
      set_node_count(n);
      stall_quiet = (ph == 2);
      random_graph(n, $urandom_range(0, 6));
    end
    stall_quiet = 0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
rtl/msfp_pkg.sv
rtl/msfp_ram.sv
rtl/msfp_ctrl.sv
rtl/msfp_dpath.sv
rtl/max_spanning_forest_prim_core.sv
verif/msfp_checker.sv
verif/tb_top.sv
